>>> hw/rtl/weave_pattern_texel_assert.svh
// Assertion macros used by the woven-pattern texel checker
`ifndef WEAVE_PATTERN_TEXEL_ASSERT_SVH
`define WEAVE_PATTERN_TEXEL_ASSERT_SVH

// Same-cycle implication, masked while reset is high
`define WPT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is high
`define WPT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also covers the reset cycles
`define WPT_ASSERT_NXT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/wpt_pkg.sv
// Shared widths, register indices, codes and tables of the woven-pattern texel block
package wpt_pkg;

  // coordinate fraction bits and derived widths
  localparam int FRAC_W      = 16;
  localparam int TILE_W      = 8;
  localparam int RUN_W       = 4;
  localparam int ROWS_W      = RUN_W + 1;
  localparam int PERIOD_W    = 9;
  localparam int X_W         = 13;
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 20;
  localparam int WIDTH_W     = 16;
  localparam int BAND_W      = FRAC_W + 17;
  localparam int COLOR_W     = 32;
  localparam int KIND_W      = 2;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 32;

  // register indices
  localparam logic [CFG_IDX_W-1:0] REG_OVERRUN    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNDERRUN   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP       = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTHS     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WARP_COL   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WEFT_COL   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COL     = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TILING     = 4'd7;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT      = 4'd8;

  // register reset values
  localparam logic [RUN_W-1:0]      RST_OVERRUN  = 4'd1;
  localparam logic [RUN_W-1:0]      RST_UNDERRUN = 4'd1;
  localparam logic [RUN_W-1:0]      RST_SKIP     = 4'd1;
  localparam logic [2*WIDTH_W-1:0]  RST_WIDTHS   = 32'hCCCC_CCCD;
  localparam logic [COLOR_W-1:0]    RST_WARP_COL = 32'hFFFF_FFFF;
  localparam logic [COLOR_W-1:0]    RST_WEFT_COL = 32'hFF00_0000;
  localparam logic [COLOR_W-1:0]    RST_BG_COL   = 32'hFF00_0000;
  localparam logic [2*TILE_W-1:0]   RST_TILING   = 16'h0404;
  localparam logic [PERIOD_W-1:0]   RST_PERIOD   = 9'd2;

  // thread kind codes
  localparam logic [KIND_W-1:0] KIND_BG   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WARP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WEFT = 2'd2;

  // ceil(2^RECIP_SHIFT / r) for the row counts one to thirty
  function automatic logic [RECIP_W-1:0] recip_of(input logic [ROWS_W-1:0] r);
    logic [RECIP_W-1:0] v;
    unique case (r)
      5'd1:    v = 21'd1048576;
      5'd2:    v = 21'd524288;
      5'd3:    v = 21'd349526;
      5'd4:    v = 21'd262144;
      5'd5:    v = 21'd209716;
      5'd6:    v = 21'd174763;
      5'd7:    v = 21'd149797;
      5'd8:    v = 21'd131072;
      5'd9:    v = 21'd116509;
      5'd10:   v = 21'd104858;
      5'd11:   v = 21'd95326;
      5'd12:   v = 21'd87382;
      5'd13:   v = 21'd80660;
      5'd14:   v = 21'd74899;
      5'd15:   v = 21'd69906;
      5'd16:   v = 21'd65536;
      5'd17:   v = 21'd61681;
      5'd18:   v = 21'd58255;
      5'd19:   v = 21'd55189;
      5'd20:   v = 21'd52429;
      5'd21:   v = 21'd49933;
      5'd22:   v = 21'd47663;
      5'd23:   v = 21'd45591;
      5'd24:   v = 21'd43691;
      5'd25:   v = 21'd41944;
      5'd26:   v = 21'd40330;
      5'd27:   v = 21'd38837;
      5'd28:   v = 21'd37450;
      5'd29:   v = 21'd36158;
      5'd30:   v = 21'd34953;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/wpt_coord_if.sv
// Coordinate channel: valid/ready with one texture coordinate pair
interface wpt_coord_if
  import wpt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FRAC_W-1:0] coord_u;
  logic [FRAC_W-1:0] coord_v;

  modport source (output valid, output coord_u, output coord_v, input ready);
  modport sink   (input valid, input coord_u, input coord_v, output ready);
endinterface

>>> hw/rtl/wpt_texel_if.sv
// Texel channel: valid/ready with one colour and its thread kind
interface wpt_texel_if
  import wpt_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] texel_color;
  logic [KIND_W-1:0]  thread_kind;

  modport source (output valid, output texel_color, output thread_kind, input ready);
  modport sink   (input valid, input texel_color, input thread_kind, output ready);
endinterface

>>> hw/rtl/weave_pattern_texel.sv
// Woven twill pattern texel generator: one colour per texture coordinate pair
//
// Channels: coord (sink) takes coord_u/coord_v as unsigned Q0.16; texel (source)
// returns texel_color (RGBA8) and thread_kind (0 background, 1 warp, 2 weft).
// Both use valid/ready; a transfer happens on a clock edge with both high.
// Configuration: cfg_we, cfg_index, cfg_data write one register per cycle;
// indices beyond seven are ignored. Write only while no texel is in flight.
// Throughput: one coordinate per cycle while texel is not stalled and no column
// count is being rebuilt, through the six-stage pipeline (tile multiply, cell
// multiply, twill sum and band test, reciprocal multiply, remainder, colour
// select into the output register).
// After each register write the column count lcm(skip, rows) is rebuilt by a
// step-by-step multiple search, one step a cycle; coord.ready stays low while
// the search loads its multiples and runs.
// Reset: synchronous, active high; all settings return to their defaults and
// the pipeline empties. A stalled receiver holds the output register; each
// stage keeps filling while it has a free slot, so bubbles are squeezed out.
module weave_pattern_texel
  import wpt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  wpt_coord_if.sink             coord,
  wpt_texel_if.source           texel
);

  typedef enum logic [1:0] {LCM_IDLE, LCM_LOAD, LCM_RUN} lcm_state_t;

  // configuration registers
  logic [RUN_W-1:0]     overrun, underrun, skip;
  logic [2*WIDTH_W-1:0] thread_widths;
  logic [COLOR_W-1:0]   warp_color, weft_color, background_color;
  logic [2*TILE_W-1:0]  tiling;

  // column count search
  lcm_state_t           lcm_state;
  logic [PERIOD_W-1:0]  mul_a, mul_b, column_period;

  logic [RUN_W-1:0]  eff_skip;
  logic [ROWS_W-1:0] rows_sum, eff_rows;
  logic              cfg_hit;

  // pipeline registers
  logic                v1, v2, v3, v4, v5, ov;
  logic [FRAC_W-1:0]   fx, fy;
  logic [PERIOD_W-1:0] ix;
  logic [ROWS_W-1:0]   iy;
  logic [FRAC_W-1:0]   cx, cy;
  logic [X_W-1:0]      x3, x4, q4;
  logic                warp_in3, weft_in3, warp_in4, weft_in4, warp_in5, weft_in5;
  logic [ROWS_W-1:0]   phase;
  logic [COLOR_W-1:0]  texel_color;
  logic [KIND_W-1:0]   thread_kind;

  logic ld1, ld2, ld3, ld4, ld5, ldo, take;

  // stage products
  logic [FRAC_W+TILE_W-1:0]       mu, mv;
  logic [FRAC_W+PERIOD_W-1:0]     px;
  logic [FRAC_W+ROWS_W-1:0]       py;
  logic [X_W-1:0]                 x_sum;
  logic [X_W+RECIP_W-1:0]         prod;
  logic [X_W+ROWS_W-1:0]          qr, rem_full;
  logic                           warp_top;
  logic [KIND_W-1:0]              kind_next;
  logic [COLOR_W-1:0]             color_next;

  // strict band test: (1 - w)/2 < c < (1 + w)/2 at scale 2^(FRAC_W+17)
  function automatic logic in_band(input logic [FRAC_W-1:0] c,
                                   input logic [WIDTH_W-1:0] w);
    logic [BAND_W-1:0] lhs, one, ws;
    lhs = BAND_W'(c) << 17;
    one = BAND_W'(1) << (FRAC_W + 16);
    ws  = BAND_W'(w) << FRAC_W;
    return (lhs > one - ws) && (lhs < one + ws);
  endfunction

  // effective run settings
  assign eff_skip = (skip == '0) ? RUN_W'(1) : skip;
  assign rows_sum = ROWS_W'(overrun) + ROWS_W'(underrun);
  assign eff_rows = (rows_sum == '0) ? ROWS_W'(1) : rows_sum;
  assign cfg_hit  = cfg_we && (cfg_index < REG_COUNT);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      overrun          <= RST_OVERRUN;
      underrun         <= RST_UNDERRUN;
      skip             <= RST_SKIP;
      thread_widths    <= RST_WIDTHS;
      warp_color       <= RST_WARP_COL;
      weft_color       <= RST_WEFT_COL;
      background_color <= RST_BG_COL;
      tiling           <= RST_TILING;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OVERRUN:  overrun          <= cfg_data[RUN_W-1:0];
        REG_UNDERRUN: underrun         <= cfg_data[RUN_W-1:0];
        REG_SKIP:     skip             <= cfg_data[RUN_W-1:0];
        REG_WIDTHS:   thread_widths    <= cfg_data[2*WIDTH_W-1:0];
        REG_WARP_COL: warp_color       <= cfg_data[COLOR_W-1:0];
        REG_WEFT_COL: weft_color       <= cfg_data[COLOR_W-1:0];
        REG_BG_COL:   background_color <= cfg_data[COLOR_W-1:0];
        REG_TILING:   tiling           <= cfg_data[2*TILE_W-1:0];
        default:      ;
      endcase
    end
  end

  // lcm search: step the smaller of two running multiples until they meet
  always_ff @(posedge clk) begin
    if (rst) begin
      lcm_state     <= LCM_IDLE;
      column_period <= RST_PERIOD;
    end else if (cfg_hit) begin
      lcm_state <= LCM_LOAD;
    end else begin
      unique case (lcm_state)
        LCM_IDLE: ;
        LCM_LOAD: begin
          mul_a     <= PERIOD_W'(eff_skip);
          mul_b     <= PERIOD_W'(eff_rows);
          lcm_state <= LCM_RUN;
        end
        LCM_RUN: begin
          if (mul_a < mul_b) begin
            mul_a <= mul_a + PERIOD_W'(eff_skip);
          end else if (mul_b < mul_a) begin
            mul_b <= mul_b + PERIOD_W'(eff_rows);
          end else begin
            column_period <= mul_a;
            lcm_state     <= LCM_IDLE;
          end
        end
        default: lcm_state <= LCM_IDLE;
      endcase
    end
  end

  // per-stage load enables; a stage loads when empty or when it drains
  assign ldo  = !ov || texel.ready;
  assign ld5  = !v5 || ldo;
  assign ld4  = !v4 || ld5;
  assign ld3  = !v3 || ld4;
  assign ld2  = !v2 || ld3;
  assign ld1  = !v1 || ld2;
  assign coord.ready = ld1 && (lcm_state == LCM_IDLE);
  assign take = coord.valid && coord.ready;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (ld1) v1 <= take;
      if (ld2) v2 <= v1;
      if (ld3) v3 <= v2;
      if (ld4) v4 <= v3;
      if (ld5) v5 <= v4;
      if (ldo) ov <= v5;
    end
  end

  // stage 1: scale by tiling and wrap
  assign mu = coord.coord_u * tiling[TILE_W-1:0];
  assign mv = coord.coord_v * tiling[2*TILE_W-1:TILE_W];

  always_ff @(posedge clk) begin
    if (ld1 && take) begin
      fx <= mu[FRAC_W-1:0];
      fy <= mv[FRAC_W-1:0];
    end
  end

  // stage 2: cell index and in-cell position
  assign px = fx * column_period;
  assign py = fy * eff_rows;

  always_ff @(posedge clk) begin
    if (ld2 && v1) begin
      ix <= px[FRAC_W +: PERIOD_W];
      iy <= py[FRAC_W +: ROWS_W];
      cx <= px[FRAC_W-1:0];
      cy <= py[FRAC_W-1:0];
    end
  end

  // stage 3: twill sum and thread band tests
  assign x_sum = X_W'(iy) + X_W'(eff_skip) * X_W'(ix);

  always_ff @(posedge clk) begin
    if (ld3 && v2) begin
      x3       <= x_sum;
      warp_in3 <= in_band(cx, thread_widths[WIDTH_W-1:0]);
      weft_in3 <= in_band(cy, thread_widths[2*WIDTH_W-1:WIDTH_W]);
    end
  end

  // stage 4: quotient by reciprocal multiply
  assign prod = x3 * recip_of(eff_rows);

  always_ff @(posedge clk) begin
    if (ld4 && v3) begin
      q4       <= prod[RECIP_SHIFT +: X_W];
      x4       <= x3;
      warp_in4 <= warp_in3;
      weft_in4 <= weft_in3;
    end
  end

  // stage 5: remainder gives the twill phase
  assign qr       = q4 * eff_rows;
  assign rem_full = (X_W+ROWS_W)'(x4) - qr;

  always_ff @(posedge clk) begin
    if (ld5 && v4) begin
      phase    <= rem_full[ROWS_W-1:0];
      warp_in5 <= warp_in4;
      weft_in5 <= weft_in4;
    end
  end

  // stage 6: thread on top wins where both cover
  assign warp_top = phase < ROWS_W'(overrun);

  always_comb begin
    if (warp_top) begin
      kind_next = warp_in5 ? KIND_WARP : (weft_in5 ? KIND_WEFT : KIND_BG);
    end else begin
      kind_next = weft_in5 ? KIND_WEFT : (warp_in5 ? KIND_WARP : KIND_BG);
    end
    unique case (kind_next)
      KIND_WARP: color_next = warp_color;
      KIND_WEFT: color_next = weft_color;
      default:   color_next = background_color;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ldo && v5) begin
      texel_color <= color_next;
      thread_kind <= kind_next;
    end
  end

  assign texel.valid       = ov;
  assign texel.texel_color = texel_color;
  assign texel.thread_kind = thread_kind;

endmodule

>>> hw/rtl/wpt_checker.sv
// Port-level checker for the woven-pattern texel block, bound to the top level
`include "weave_pattern_texel_assert.svh"

module wpt_checker
  import wpt_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [COLOR_W-1:0]   texel_color,
  input logic [KIND_W-1:0]    thread_kind
);

  // reset empties the output register
  `WPT_ASSERT_NXT_RST(a_rst_empty, rst, !out_valid, "output valid after reset")

  // only the three thread codes leave the block
  `WPT_ASSERT_IMP(a_kind_legal, out_valid,
    thread_kind == KIND_BG || thread_kind == KIND_WARP || thread_kind == KIND_WEFT,
    "illegal thread kind")

  // a register write holds off coordinates while the column count is rebuilt
  `WPT_ASSERT_NXT(a_cfg_holdoff, cfg_we && cfg_index < REG_COUNT, !in_ready,
    "coordinate taken during column count rebuild")

  // a stalled result stays put until its transfer
  `WPT_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(texel_color) && $stable(thread_kind),
    "stalled texel changed")

endmodule

bind weave_pattern_texel wpt_checker u_wpt_checker (
  .clk         (clk),
  .rst         (rst),
  .cfg_we      (cfg_we),
  .cfg_index   (cfg_index),
  .in_ready    (coord.ready),
  .out_valid   (texel.valid),
  .out_ready   (texel.ready),
  .texel_color (texel.texel_color),
  .thread_kind (texel.thread_kind)
);

>>> verif/weave_pattern_texel_test.sv
// Self-checking testbench for the woven twill pattern texel generator
`timescale 1ns / 1ps

module weave_pattern_texel_test;
  import wpt_pkg::*;

  localparam int RX_HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES    = 16;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [KIND_W-1:0]  kind;
  } woven_texel_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  wpt_coord_if coord_ch ();
  wpt_texel_if texel_ch ();

  weave_pattern_texel u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coord     (coord_ch),
    .texel     (texel_ch)
  );

  // shadow copy of the pattern registers
  logic [RUN_W-1:0]     pat_overrun;
  logic [RUN_W-1:0]     pat_underrun;
  logic [RUN_W-1:0]     pat_skip;
  logic [2*WIDTH_W-1:0] pat_widths;
  logic [COLOR_W-1:0]   pat_warp;
  logic [COLOR_W-1:0]   pat_weft;
  logic [COLOR_W-1:0]   pat_bg;
  logic [2*TILE_W-1:0]  pat_tiling;
  int unsigned          pat_columns;

  woven_texel_t texel_due[$];
  int unsigned  mismatches;
  int unsigned  tx_idle_pct;
  int unsigned  rx_idle_pct;
  int unsigned  hold_asks;
  int unsigned  hold_served;

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Pattern predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned row_count();
    int unsigned n;
    n = pat_overrun;
    n = n + pat_underrun;
    return (n == 0) ? 1 : n;
  endfunction

  function automatic int unsigned twill_step();
    return (pat_skip == '0) ? 1 : pat_skip;
  endfunction

  // lcm of twill step and row count
  function automatic int unsigned column_count();
    int unsigned s, n, a, b, t;
    s = twill_step();
    n = row_count();
    a = s;
    b = n;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return (s / a) * n;
  endfunction

  // strict band test at scale 2^33: (1 - w)/2 < c < (1 + w)/2
  function automatic bit thread_covers(input longint unsigned c, input longint unsigned w);
    longint unsigned pos, one_q, half_w;
    pos    = c << 17;
    one_q  = 64'd1 << 32;
    half_w = w << 16;
    return (pos > one_q - half_w) && (pos < one_q + half_w);
  endfunction

  function automatic woven_texel_t weave_texel(input logic [FRAC_W-1:0] u,
                                               input logic [FRAC_W-1:0] v);
    longint unsigned lu, lv, fx, fy, px, py, ix, iy, phase, rows, frac_mask;
    bit warp_top, warp_in, weft_in;
    woven_texel_t r;
    frac_mask = (64'd1 << FRAC_W) - 1;
    lu = u;
    lv = v;
    rows = row_count();
    fx = (lu * pat_tiling[TILE_W-1:0]) & frac_mask;
    fy = (lv * pat_tiling[2*TILE_W-1:TILE_W]) & frac_mask;
    px = fx * pat_columns;
    py = fy * rows;
    ix = px >> FRAC_W;
    iy = py >> FRAC_W;
    phase = (iy + twill_step() * ix) % rows;
    warp_top = phase < pat_overrun;
    warp_in = thread_covers(px & frac_mask, pat_widths[WIDTH_W-1:0]);
    weft_in = thread_covers(py & frac_mask, pat_widths[2*WIDTH_W-1:WIDTH_W]);
    if (warp_top)
      r.kind = warp_in ? KIND_WARP : (weft_in ? KIND_WEFT : KIND_BG);
    else
      r.kind = weft_in ? KIND_WEFT : (warp_in ? KIND_WARP : KIND_BG);
    case (r.kind)
      KIND_WARP: r.color = pat_warp;
      KIND_WEFT: r.color = pat_weft;
      default:   r.color = pat_bg;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // one register write; only called while nothing is in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_OVERRUN:  pat_overrun  = data[RUN_W-1:0];
      REG_UNDERRUN: pat_underrun = data[RUN_W-1:0];
      REG_SKIP:     pat_skip     = data[RUN_W-1:0];
      REG_WIDTHS:   pat_widths   = data;
      REG_WARP_COL: pat_warp     = data;
      REG_WEFT_COL: pat_weft     = data;
      REG_BG_COL:   pat_bg       = data;
      REG_TILING:   pat_tiling   = data[2*TILE_W-1:0];
      default: ;
    endcase
    pat_columns = column_count();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // offer one coordinate pair and wait for its transfer
  task automatic send_coord(input logic [FRAC_W-1:0] u, input logic [FRAC_W-1:0] v);
    bit offered;
    offered = 1'b0;
    while (!offered) begin
      @(negedge clk);
      if ($urandom_range(99) < tx_idle_pct) begin
        coord_ch.valid <= 1'b0;
      end else begin
        coord_ch.valid   <= 1'b1;
        coord_ch.coord_u <= u;
        coord_ch.coord_v <= v;
        offered = 1'b1;
      end
    end
    do @(posedge clk); while (!coord_ch.ready);
    texel_due.push_back(weave_texel(u, v));
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    coord_ch.valid <= 1'b0;
    while (texel_due.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, plus a long hold-off when one is asked for
  initial begin : rx_drive
    int unsigned hold_left;
    hold_left = 0;
    hold_served = 0;
    texel_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != hold_served) begin
        hold_served++;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        texel_ch.ready <= 1'b0;
      end else begin
        texel_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // compare each texel transfer with the oldest prediction
  always @(posedge clk) begin : texel_check
    woven_texel_t want;
    if (!rst && texel_ch.valid && texel_ch.ready) begin
      if (texel_due.size() == 0) begin
        $error("unexpected texel: texel_color %h thread_kind %0d",
               texel_ch.texel_color, texel_ch.thread_kind);
        mismatches++;
      end else begin
        want = texel_due.pop_front();
        if (texel_ch.texel_color !== want.color) begin
          $error("texel_color: expected %h, got %h", want.color, texel_ch.texel_color);
          mismatches++;
        end
        if (texel_ch.thread_kind !== want.kind) begin
          $error("thread_kind: expected %0d, got %0d", want.kind, texel_ch.thread_kind);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Random choices
  // ---------------------------------------------------------------------------

  function automatic logic [CFG_DATA_W-1:0] pick_run();
    logic [CFG_DATA_W-1:0] d;
    d = $urandom;
    case ($urandom_range(9))
      0:       d[RUN_W-1:0] = '0;
      1:       d[RUN_W-1:0] = '1;
      default: d[RUN_W-1:0] = RUN_W'($urandom_range(15));
    endcase
    return d;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_widths();
    logic [CFG_DATA_W-1:0] d;
    d = $urandom;
    case ($urandom_range(7))
      0: d = '0;
      1: d = '1;
      2: d[2*WIDTH_W-1:WIDTH_W] = '0;
      3: d[WIDTH_W-1:0] = '1;
      default: ;
    endcase
    return d;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_tiling();
    logic [CFG_DATA_W-1:0] d;
    d = $urandom;
    case ($urandom_range(7))
      0: d[2*TILE_W-1:0] = '0;
      1: d[2*TILE_W-1:0] = '1;
      2: d[2*TILE_W-1:0] = 16'h0101;
      3: d[TILE_W-1:0] = TILE_W'($urandom_range(1, 6));
      default: ;
    endcase
    return d;
  endfunction

  function automatic logic [FRAC_W-1:0] pick_coord();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      default: return FRAC_W'($urandom);
    endcase
  endfunction

  task automatic randomise_pattern();
    write_reg(REG_OVERRUN, pick_run());
    write_reg(REG_UNDERRUN, pick_run());
    write_reg(REG_SKIP, pick_run());
    write_reg(REG_WIDTHS, pick_widths());
    write_reg(REG_WARP_COL, $urandom);
    write_reg(REG_WEFT_COL, $urandom);
    write_reg(REG_BG_COL, $urandom);
    write_reg(REG_TILING, pick_tiling());
    // an index past the register file must change nothing
    if ($urandom_range(3) == 0)
      write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, {CFG_IDX_W{1'b1}})), $urandom);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_reset_pattern();
    send_coord('0, '0);
    send_coord('1, '1);
    send_coord(16'h8000, 16'h0000);
    send_coord(16'h0000, 16'h8000);
    send_coord(16'h2000, 16'h6000);
    pause_until_drained();
  endtask

  // one row, one column: in-cell position equals the coordinate,
  // so the band edges can be hit exactly
  task automatic test_strict_band_edges();
    write_reg(REG_OVERRUN, 32'd1);
    write_reg(REG_UNDERRUN, 32'd0);
    write_reg(REG_SKIP, 32'd1);
    write_reg(REG_WIDTHS, 32'h4000_4000);
    write_reg(REG_TILING, 32'h0101);
    send_coord(16'd24576, 16'd24576);
    send_coord(16'd24577, 16'd24577);
    send_coord(16'd40959, 16'd40959);
    send_coord(16'd40960, 16'd40960);
    send_coord(16'd24577, 16'd40960);
    pause_until_drained();
    // no warp rows: weft on top wherever both cover
    write_reg(REG_OVERRUN, 32'd0);
    write_reg(REG_UNDERRUN, 32'd1);
    send_coord(16'd32768, 16'd32768);
    send_coord(16'd32768, 16'd0);
    pause_until_drained();
  endtask

  task automatic test_degenerate_settings();
    // overrun and underrun both zero, skip zero
    write_reg(REG_UNDERRUN, 32'd0);
    write_reg(REG_SKIP, 32'd0);
    write_reg(REG_TILING, 32'h0303);
    send_coord(16'h5555, 16'h8000);
    send_coord(16'h8000, 16'h5555);
    pause_until_drained();
    // tiling zero wraps both coordinates to the origin; zero width never covers
    write_reg(REG_OVERRUN, 32'd15);
    write_reg(REG_UNDERRUN, 32'd15);
    write_reg(REG_SKIP, 32'd15);
    write_reg(REG_TILING, 32'h0000);
    write_reg(REG_WIDTHS, 32'h0000_FFFF);
    send_coord(16'hFFFF, 16'hFFFF);
    pause_until_drained();
    write_reg(REG_TILING, 32'hFFFF);
    send_coord(16'hFFFF, 16'h1234);
    send_coord(16'h0001, 16'hFFFF);
    pause_until_drained();
    // out-of-range indices are ignored
    write_reg(REG_COUNT, 32'hFFFF_FFFF);
    write_reg({CFG_IDX_W{1'b1}}, 32'h0000_0000);
    write_reg(REG_WIDTHS, 32'hFFFF_0000);
    send_coord(16'h4321, 16'h9ABC);
    send_coord(16'h0000, 16'hFFFF);
    pause_until_drained();
  endtask

  task automatic test_random_patterns(input int unsigned tx_pct, input int unsigned rx_pct,
                                      input int unsigned phases, input int unsigned per_phase);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (phases) begin
      randomise_pattern();
      repeat (per_phase) send_coord(pick_coord(), pick_coord());
      pause_until_drained();
    end
  endtask

  // receiver holds off while the sender keeps offering, filling the pipeline
  task automatic test_receiver_hold();
    tx_idle_pct = 0;
    rx_idle_pct = 20;
    randomise_pattern();
    hold_asks++;
    repeat (80) send_coord(pick_coord(), pick_coord());
    pause_until_drained();
  endtask

  // sender stops until every texel has come out, then resumes
  task automatic test_sender_pause();
    tx_idle_pct = 10;
    rx_idle_pct = 30;
    repeat (30) send_coord(pick_coord(), pick_coord());
    pause_until_drained();
    repeat (30) send_coord(pick_coord(), pick_coord());
    pause_until_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    coord_ch.valid = 1'b0;
    coord_ch.coord_u = '0;
    coord_ch.coord_v = '0;
    mismatches = 0;
    hold_asks = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    pat_overrun  = RST_OVERRUN;
    pat_underrun = RST_UNDERRUN;
    pat_skip     = RST_SKIP;
    pat_widths   = RST_WIDTHS;
    pat_warp     = RST_WARP_COL;
    pat_weft     = RST_WEFT_COL;
    pat_bg       = RST_BG_COL;
    pat_tiling   = RST_TILING;
    pat_columns  = column_count();
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    test_reset_pattern();
    test_strict_band_edges();
    test_degenerate_settings();
    test_random_patterns(38, 70, 9, 45);
    test_random_patterns(70, 38, 9, 45);
    test_random_patterns(0, 0, 9, 45);
    test_receiver_hold();
    test_sender_pause();

    pause_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> weave_pattern_texel.f
+incdir+hw/rtl
hw/rtl/wpt_pkg.sv
hw/rtl/wpt_coord_if.sv
hw/rtl/wpt_texel_if.sv
hw/rtl/weave_pattern_texel.sv
hw/rtl/wpt_checker.sv
verif/weave_pattern_texel_test.sv
